// File: design/sbda_pkg.sv
package sbda_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic conv_step;
      logic skip_step;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic conv_done;
      logic top_zero;
      logic more_digits;
      logic out_free;
      logic neg;
   } status_type;

endpackage

// File: design/sbda_ctrl.sv
module sbda_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sbda_pkg::status_type status,
   output sbda_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      IDLE,
      CONV,
      SKIP,
      SIGN,
      EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = CONV;
            end
         end
         CONV: begin
            cmd.conv_step = 1'b1;
            if (status.conv_done) begin
               state_in = SKIP;
            end
         end
         SKIP: begin
            // drop leading zero digits, the ones digit always stays
            if (status.top_zero && status.more_digits) begin
               cmd.skip_step = 1'b1;
            end else if (status.neg) begin
               state_in = SIGN;
            end else begin
               state_in = EMIT;
            end
         end
         SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = EMIT;
            end
         end
         EMIT: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (!status.more_digits) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_sign_only_neg: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_sign |-> status.neg)
      else $error("minus sign emitted for a non-negative value");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> status.out_free)
      else $error("character emitted over a pending transfer");
`endif

endmodule

// File: design/sbda_dp.sv
module sbda_dp #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [DATA_WIDTH-1:0]    value,
   input  sbda_pkg::cmd_type        cmd,
   output sbda_pkg::status_type     status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [7:0]               character,
   output logic                     last
);

   // decimal digits of 2^(DATA_WIDTH-1), via log10(2) ~ 0.30103
   localparam int NUM_DIGITS = ((DATA_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int BCD_WIDTH  = NUM_DIGITS * 4;
   localparam int BIT_CNT_W  = $clog2(DATA_WIDTH);
   localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

   logic [DATA_WIDTH-1:0] mag_ff;
   logic [DATA_WIDTH-1:0] mag_in;
   logic [BCD_WIDTH-1:0]  bcd_ff;
   logic [BCD_WIDTH-1:0]  bcd_in;
   logic [BCD_WIDTH-1:0]  bcd_adj;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff;
   logic [BIT_CNT_W-1:0]  bit_cnt_in;
   logic [DIG_CNT_W-1:0]  dig_cnt_ff;
   logic [DIG_CNT_W-1:0]  dig_cnt_in;
   logic                  neg_ff;
   logic                  neg_in;
   logic                  rsp_tvalid_ff;
   logic                  rsp_tvalid_in;
   logic [7:0]            char_ff;
   logic [7:0]            char_in;
   logic                  last_ff;
   logic                  last_in;
   logic [3:0]            top_digit;

   assign top_digit = bcd_ff[BCD_WIDTH-1 -: 4];

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      mag_in        = mag_ff;
      bcd_in        = bcd_ff;
      bit_cnt_in    = bit_cnt_ff;
      dig_cnt_in    = dig_cnt_ff;
      neg_in        = neg_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (cmd.load) begin
         neg_in     = value[DATA_WIDTH-1];
         mag_in     = value[DATA_WIDTH-1] ? ({DATA_WIDTH{1'b0}} - value) : value;
         bcd_in     = '0;
         bit_cnt_in = BIT_CNT_W'(DATA_WIDTH - 1);
         dig_cnt_in = DIG_CNT_W'(NUM_DIGITS - 1);
      end
      if (cmd.conv_step) begin
         bcd_in     = {bcd_adj[BCD_WIDTH-2:0], mag_ff[DATA_WIDTH-1]};
         mag_in     = {mag_ff[DATA_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end
      if (cmd.skip_step || cmd.emit_digit) begin
         bcd_in     = {bcd_ff[BCD_WIDTH-5:0], 4'd0};
         dig_cnt_in = dig_cnt_ff - 1'b1;
      end
      if (cmd.emit_sign) begin
         char_in       = sbda_pkg::CHAR_MINUS;
         last_in       = 1'b0;
         rsp_tvalid_in = 1'b1;
      end
      if (cmd.emit_digit) begin
         char_in       = 8'(sbda_pkg::CHAR_ZERO + {4'd0, top_digit});
         last_in       = (dig_cnt_ff == '0);
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      neg_ff     <= neg_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign status.conv_done   = (bit_cnt_ff == '0);
   assign status.top_zero    = (top_digit == 4'd0);
   assign status.more_digits = (dig_cnt_ff != '0);
   assign status.out_free    = !rsp_tvalid_ff || rsp_tready;
   assign status.neg         = neg_ff;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign character  = char_ff;
   assign last       = last_ff;

`ifndef SYNTH
   a_no_skip_in_conv: assert property (@(posedge clock) disable iff (reset)
      cmd.conv_step |-> (dig_cnt_ff == DIG_CNT_W'(NUM_DIGITS - 1)))
      else $error("digit count moved during conversion");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_digit |-> (top_digit <= 4'd9))
      else $error("non-decimal digit emitted");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (bcd_ff == '0))
      else $error("digit register not cleared on load");
`endif

endmodule

// File: design/signed_binary_to_decimal_ascii_unit.sv
// Signed binary to decimal ASCII text.
// req channel: one transfer carries a signed two's complement value of
// DATA_WIDTH bits in req_tdata. rsp channel: one transfer per character,
// rsp_tdata holds the ASCII code, rsp_tlast marks the final character.
// Text is an optional '-' and then the digits, most significant first,
// with no leading zeros; zero gives a single '0'.
// Order of work: the req transfer, then bit-serial double dabble over all
// DATA_WIDTH bits, then dropping the leading zero digits one at a time,
// then the characters, each sent while the receiver is ready.
// One value is worked on at a time; req_tready is high only while idle.
// The result sits in an output register, so the next value is taken while
// the final character still waits for its transfer.
// A stalled receiver holds the character and pauses emission.
// Synchronous reset returns to idle and drops rsp_tvalid.
module signed_binary_to_decimal_ascii_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // value [DATA_WIDTH-1:0], zero padded to whole bytes
   input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // character [7:0]
   output logic [7:0]                            rsp_tdata,
   output logic                                  rsp_tlast
);

   sbda_pkg::cmd_type    cmd;
   sbda_pkg::status_type status;

   sbda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sbda_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[DATA_WIDTH-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .character  (rsp_tdata),
      .last       (rsp_tlast)
   );

endmodule
